>>> sv/mrf_pkg.sv
// Package for the request framer: request type, register indexes, reset values
// and the byte-wide CRC-16 update. Used by every module of the block.
`timescale 1ns / 1ps

package mrf_pkg;

  // Request queue depth between the front and the back
  localparam int MRF_QDEPTH = 2;

  // Configuration register indexes
  localparam int          REG_IDX_W     = 1;
  localparam logic [0:0]  REG_UNIT_ID   = 1'b0;
  localparam logic [0:0]  REG_FUNC_CODE = 1'b1;

  // Configuration reset values
  localparam logic [7:0]  UNIT_ID_RST   = 8'hFD;
  localparam logic [7:0]  FUNC_CODE_RST = 8'h04;

  // Modbus CRC-16, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte positions in the frame
  localparam logic [2:0]  IDX_UNIT   = 3'd0;
  localparam logic [2:0]  IDX_FUNC   = 3'd1;
  localparam logic [2:0]  IDX_ADDR_H = 3'd2;
  localparam logic [2:0]  IDX_ADDR_L = 3'd3;
  localparam logic [2:0]  IDX_VAL_H  = 3'd4;
  localparam logic [2:0]  IDX_VAL_L  = 3'd5;
  localparam logic [2:0]  IDX_CRC_L  = 3'd6;
  localparam logic [2:0]  IDX_CRC_H  = 3'd7;

  typedef struct packed {
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [15:0] addr;
    logic [15:0] value;
  } mrf_req_t;

  // Queue head as seen by the back
  typedef struct packed {
    logic     valid;
    mrf_req_t req;
  } mrf_head_t;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Header byte of a request at a frame position (CRC positions give zero)
  function automatic logic [7:0] hdr_byte(input mrf_req_t req, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      IDX_UNIT:   b = req.unit_id;
      IDX_FUNC:   b = req.func_code;
      IDX_ADDR_H: b = req.addr[15:8];
      IDX_ADDR_L: b = req.addr[7:0];
      IDX_VAL_H:  b = req.value[15:8];
      IDX_VAL_L:  b = req.value[7:0];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> sv/modbus_rtu_request_framer_top.sv
// Modbus RTU request framer, top level: joins the request front and the
// byte serializer back. Uses mrf_pkg, mrf_front and mrf_back.
//
// Usage:
//   in_*  : one request per item; in_tdata = register address (low 16 bits),
//           register value (high 16 bits).
//   out_* : eight items per request, one frame byte each, in transmit order:
//           unit id, function code, address high/low, value high/low,
//           CRC low, CRC high. out_tlast marks the CRC high byte.
//   cfg_* : cfg_addr 0 = unit id, 1 = function code; write only while idle.
// Path: an accepted request is written into the queue, and its first byte is then
// loaded into the output register.
// Throughput: one byte per cycle while out_tready stays high, set by the
// single output byte lane; the CRC is folded one byte per cycle on the way.
// The request queue holds QDEPTH requests, so requests are taken while a frame
// is still being sent.
// Reset (rst_n low, synchronous) empties the queue and output register and
// loads unit id 0xFD and function code 0x04.
// A stall on out_tready holds the current byte; the queue fills and then
// in_tready drops.
`timescale 1ns / 1ps

module modbus_rtu_request_framer_top
  import mrf_pkg::*;
#(
  parameter int QDEPTH = MRF_QDEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [15:0] register_address, [31:16] register_value
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] frame_byte
  output logic                 out_tlast   // last_byte
);

  mrf_head_t head;
  logic      pop;

  mrf_front #(
    .QDEPTH(QDEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_addr   (in_tdata[15:0]),
    .in_value  (in_tdata[31:16]),
    .head      (head),
    .pop       (pop)
  );

  mrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sv/mrf_front.sv
// Front of the request framer: configuration registers and the request queue.
// Stamps each accepted request with unit id and function code. Uses mrf_pkg.
`timescale 1ns / 1ps

module mrf_front
  import mrf_pkg::*;
#(
  parameter int QDEPTH = MRF_QDEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_addr,
  input  logic [15:0]          in_value,
  output mrf_head_t            head,
  input  logic                 pop
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QDEPTH);

  logic [7:0]    unit_id_r, func_code_r;
  mrf_req_t      mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_id_r   <= UNIT_ID_RST;
      func_code_r <= FUNC_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_UNIT_ID:   unit_id_r   <= cfg_wdata;
        REG_FUNC_CODE: func_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = (count_r != CNT_FULL);
  assign push      = in_tvalid && in_tready;

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage, stamped with the current header registers
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{unit_id: unit_id_r, func_code: func_code_r,
                           addr: in_addr, value: in_value};
    end
  end

  assign head.valid = (count_r != '0);
  assign head.req   = mem_r[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("request queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0) else $error("pop from empty request queue");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_FULL) |-> !push) else $error("push into full request queue");

endmodule

>>> sv/mrf_back.sv
// Back of the request framer: serializes one request into eight frame bytes,
// folding the CRC one byte per cycle while not stalled, into a registered output. Uses mrf_pkg.
`timescale 1ns / 1ps

module mrf_back
  import mrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mrf_head_t head,
  output logic      pop,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic [7:0] out_byte,
  output logic      out_tlast
);

  mrf_req_t    req_r, req_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        active_r, active_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;
  logic        adv;
  logic [7:0]  cur_byte;

  // Output register frees when empty or taken
  assign adv = !out_valid_r || out_tready;

  always_comb begin
    req_nxt       = req_r;
    crc_nxt       = crc_r;
    idx_nxt       = idx_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    cur_byte      = 8'h00;
    if (adv) begin
      if (active_r) begin
        // Continue the frame in flight
        case (idx_r)
          IDX_CRC_L: cur_byte = crc_r[7:0];
          IDX_CRC_H: cur_byte = crc_r[15:8];
          default:   cur_byte = hdr_byte(req_r, idx_r);
        endcase
        if (idx_r != IDX_CRC_L && idx_r != IDX_CRC_H) begin
          crc_nxt = crc16_byte(crc_r, cur_byte);
        end
        out_valid_nxt = 1'b1;
        out_data_nxt  = cur_byte;
        out_last_nxt  = (idx_r == IDX_CRC_H);
        if (idx_r == IDX_CRC_H) begin
          active_nxt = 1'b0;
          idx_nxt    = IDX_UNIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end else if (head.valid) begin
        // Start a new frame straight from the queue head
        pop           = 1'b1;
        cur_byte      = head.req.unit_id;
        req_nxt       = head.req;
        crc_nxt       = crc16_byte(CRC_INIT, cur_byte);
        active_nxt    = 1'b1;
        idx_nxt       = IDX_FUNC;
        out_valid_nxt = 1'b1;
        out_data_nxt  = cur_byte;
        out_last_nxt  = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= IDX_UNIT;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    crc_r      <= crc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_data_r;
  assign out_tlast  = out_last_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !active_r) else $error("new request taken mid-frame");
  a_active_idx: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> idx_r != IDX_UNIT) else $error("frame position lost");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !active_r) else $error("last byte inside a frame");
  a_start_first: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r && !out_last_r && idx_r == IDX_FUNC)
    else $error("frame start not shown");

endmodule
